FILE: rtl/core/vt4_pkg.sv
// Shared types and constants for the 4x4 Q16.16 vertex transform.
// Used by vt4_coef_regs, vt4_lane and vertex_transform_4x4_unit; no dependencies.
package vt4_pkg;

   localparam int COMP_W      = 32;
   localparam int PROD_W      = 2 * COMP_W;
   localparam int PAIR_W      = PROD_W + 1;
   localparam int SUM_W       = PROD_W + 2;
   localparam int FRAC_W      = 16;
   localparam int NUM_COMP    = 4;
   localparam int NUM_PAIRS   = 8;
   localparam int PAIR_SEL_W  = 3;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 64;

   // Command codes carried by the request beat.
   localparam logic CMD_COLUMN = 1'b0;  // matrix times column vector
   localparam logic CMD_ROW    = 1'b1;  // row vector times matrix

   typedef logic signed [COMP_W-1:0]     comp_type;
   typedef comp_type [NUM_COMP-1:0]      vec_type;
   typedef vec_type [NUM_COMP-1:0]       mat_type;
   typedef logic [CSR_DATA_W-1:0]        coef_pair_type;

   // Identity matrix after reset.
   localparam coef_pair_type [NUM_PAIRS-1:0] COEF_RESET = {
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000
   };

   // Result of one lane: the saturated component and whether it was clipped.
   typedef struct packed {
      comp_type value;
      logic     sat;
   } lane_out_type;

endpackage

FILE: rtl/core/vt4_coef_regs.sv
// Coefficient register file for the vertex transform: eight 64-bit pairs.
// Presents the matrix both by rows and by columns. Depends on vt4_pkg.
module vt4_coef_regs import vt4_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  coef_pair_type          wr_data,
   output mat_type                rows,
   output mat_type                cols
);

   coef_pair_type [NUM_PAIRS-1:0] coef_ff;

   // Writes beyond the last pair are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else if (wr_en && (wr_index < CSR_INDEX_W'(NUM_PAIRS))) begin
         coef_ff[wr_index[PAIR_SEL_W-1:0]] <= wr_data;
      end
   end

   for (genvar r = 0; r < NUM_COMP; r++) begin : g_row
      for (genvar c = 0; c < NUM_COMP; c++) begin : g_col
         localparam int PairIdx = r * 2 + c / 2;
         localparam int WordLo  = (c % 2) * COMP_W;
         assign rows[r][c] = comp_type'(coef_ff[PairIdx][WordLo +: COMP_W]);
         assign cols[c][r] = comp_type'(coef_ff[PairIdx][WordLo +: COMP_W]);
      end
   end

endmodule

FILE: rtl/core/vt4_lane.sv
// One dot-product lane: four 32x32 products, a pairwise sum, then the final
// sum with round-half-up and saturation to Q16.16. Depends on vt4_pkg.
module vt4_lane import vt4_pkg::*; (
   input  logic         clock,
   input  logic         enable,
   input  logic         cmd,
   input  vec_type      row_coef,
   input  vec_type      col_coef,
   input  vec_type      vec,
   output lane_out_type result
);

   logic signed [PROD_W-1:0] prod_ff [NUM_COMP];
   logic signed [PROD_W-1:0] prod_in [NUM_COMP];
   logic signed [PAIR_W-1:0] pair_ff [2];
   logic signed [PAIR_W-1:0] pair_in [2];
   comp_type                 coef_sel [NUM_COMP];
   comp_type                 vec_s [NUM_COMP];
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-FRAC_W-1:0] quot;
   logic                     in_range;

   always_comb begin
      for (int j = 0; j < NUM_COMP; j++) begin
         coef_sel[j] = (cmd == CMD_ROW) ? col_coef[j] : row_coef[j];
         vec_s[j]    = vec[j];
         prod_in[j]  = PROD_W'(coef_sel[j]) * PROD_W'(vec_s[j]);
      end
      pair_in[0] = PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
      pair_in[1] = PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         pair_ff <= pair_in;
      end
   end

   // Adding half an LSB and dropping the fraction rounds half up.
   assign sum      = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1])
                   + SUM_W'(signed'(1 << (FRAC_W - 1)));
   assign quot     = sum[SUM_W-1:FRAC_W];
   assign in_range = (&quot[SUM_W-FRAC_W-1:COMP_W-1]) || !(|quot[SUM_W-FRAC_W-1:COMP_W-1]);

   always_comb begin
      result.sat = !in_range;
      if (in_range) begin
         result.value = quot[COMP_W-1:0];
      end else if (quot[SUM_W-FRAC_W-1]) begin
         result.value = {1'b1, {(COMP_W-1){1'b0}}};
      end else begin
         result.value = {1'b0, {(COMP_W-1){1'b1}}};
      end
   end

endmodule

FILE: rtl/core/vertex_transform_4x4_unit.sv
// Top level of the 4x4 Q16.16 vertex transform: input register, four lanes,
// merging output register. Depends on vt4_pkg, vt4_coef_regs and vt4_lane.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_cmd, req_in_x..req_in_w
//   rsp      out        rsp_valid/rsp_stall  rsp_out_x..rsp_out_w, rsp_overflow
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One vertex is accepted per clock while req_stall is low; its result passes
// through the input, product, pair-sum and output registers.
// The sixteen 32x32 multipliers, four to a lane, set the depth of the pipe.
// Reset is synchronous and restores the identity matrix and empties the pipe.
// The whole pipe moves in step: it holds while a result waits under rsp_stall,
// and req_stall is raised for exactly those cycles.
module vertex_transform_4x4_unit import vt4_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  comp_type               req_in_x,
   input  comp_type               req_in_y,
   input  comp_type               req_in_z,
   input  comp_type               req_in_w,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output comp_type               rsp_out_x,
   output comp_type               rsp_out_y,
   output comp_type               rsp_out_z,
   output comp_type               rsp_out_w,
   output logic                   rsp_overflow,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  coef_pair_type          csr_data
);

   // Pipeline control: one enable for every stage.
   logic         advance;
   logic         in_valid_ff;
   logic         prod_valid_ff;
   logic         pair_valid_ff;
   logic         out_valid_ff;

   // Stage payloads.
   logic         cmd_ff;
   vec_type      vec_ff;
   vec_type      vec_in;
   mat_type      rows;
   mat_type      cols;
   lane_out_type lane_res [NUM_COMP];
   vec_type      out_vec_ff;
   logic         overflow_ff;
   logic         overflow_in;

   // The register file is always ready to take a beat.
   assign csr_ready = 1'b1;

   vt4_coef_regs u_coef_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .rows     (rows),
      .cols     (cols)
   );

   // The pipe moves whenever the output register is empty or being emptied.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         pair_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         in_valid_ff   <= req_valid;
         prod_valid_ff <= in_valid_ff;
         pair_valid_ff <= prod_valid_ff;
         out_valid_ff  <= pair_valid_ff;
      end
   end

   assign vec_in = {req_in_w, req_in_z, req_in_y, req_in_x};

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff <= req_cmd;
         vec_ff <= vec_in;
      end
   end

   // Lane i produces component i of the result, from row i of the matrix
   // for the column product or from column i for the row product.
   for (genvar i = 0; i < NUM_COMP; i++) begin : g_lane
      vt4_lane u_lane (
         .clock    (clock),
         .enable   (advance),
         .cmd      (cmd_ff),
         .row_coef (rows[i]),
         .col_coef (cols[i]),
         .vec      (vec_ff),
         .result   (lane_res[i])
      );
   end

   // Merging stage: gather the four components and fold their flags together.
   always_comb begin
      overflow_in = 1'b0;
      for (int i = 0; i < NUM_COMP; i++) begin
         overflow_in = overflow_in | lane_res[i].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NUM_COMP; i++) begin
            out_vec_ff[i] <= lane_res[i].value;
         end
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_x    = out_vec_ff[0];
   assign rsp_out_y    = out_vec_ff[1];
   assign rsp_out_z    = out_vec_ff[2];
   assign rsp_out_w    = out_vec_ff[3];
   assign rsp_overflow = overflow_ff;

endmodule
